[rtl/core/ttlnm_pkg.sv]
// Types and codes shared by the neighbour message table.
`timescale 1ns / 1ps

package ttlnm_pkg;

    typedef enum logic [1:0] {
        ACT_RECEIVE = 2'd0,
        ACT_QUERY   = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        REG_SELF_ID     = 3'd0,
        REG_TTL_RELOAD  = 3'd1,
        REG_ANY_ROBOT   = 3'd2,
        REG_ANY_MESSAGE = 3'd3,
        REG_CONTROL_LOC = 3'd4
    } t_reg_index;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_CLEAR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0] action;
        logic [2:0] location;
        logic [7:0] sender_id;
        logic [7:0] message_id;
        logic [7:0] message_param;
        logic [7:0] query_robot;
        logic [7:0] query_message;
    } t_in_item;

    typedef struct packed {
        logic       found;
        logic [7:0] hit_robot;
        logic [7:0] hit_message;
        logic [7:0] hit_param;
        logic [7:0] hit_position;
        logic [7:0] obstacle_mask;
        logic       info_valid;
    } t_out_item;

    typedef struct packed {
        logic [7:0] robot;
        logic [7:0] message;
        logic [7:0] param;
        logic [7:0] position;
        logic [7:0] ttl;
    } t_entry;

    localparam int POS_F  = 0;
    localparam int POS_FL = 1;
    localparam int POS_FR = 2;
    localparam int POS_L  = 3;
    localparam int POS_R  = 4;
    localparam int POS_B  = 5;
    localparam int POS_BL = 6;
    localparam int POS_BR = 7;

    function automatic logic [7:0] refresh_mask(input logic [7:0] p);
        logic [7:0] q;
        q = p;
        q[POS_F] = q[POS_FL] & q[POS_FR];
        q[POS_B] = q[POS_BL] & q[POS_BR];
        q[POS_L] = q[POS_FL] & q[POS_BL];
        q[POS_R] = q[POS_FR] & q[POS_BR];
        return q;
    endfunction

endpackage

[rtl/core/ttlnm_table_ram.sv]
// Entry memory: one write port, one registered read port.
`timescale 1ns / 1ps

module ttlnm_table_ram
    import ttlnm_pkg::*;
#(
    parameter int ENTRIES = 8,
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/core/ttl_neighbor_message_table.sv]
// Top level of the neighbour message table: sequencer around the entry memory.
`timescale 1ns / 1ps

// Each item walks the table once through a memory with one write port and one
// registered read port. A query, a receive of a control or own-id message and
// the undefined action go from ST_SCAN to ST_DONE, which raises the result
// strobe. A receive that is stored passes through ST_WRITE between them for
// the write-back of the chosen entry. A clear sweeps the memory one entry a
// cycle. busy falls in the cycle in which the result shows on o_result, marked
// by o_done for that one cycle; the receiver cannot stall and must take it as
// it comes. A clearing pass, with busy high and no result, runs straight after
// reset, so every entry starts dead.
module ttl_neighbor_message_table
    import ttlnm_pkg::*;
#(
    parameter int ENTRIES = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    input  logic      i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output logic      o_done,
    output t_out_item o_result
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] LAST = CW'(ENTRIES);

    logic [7:0] r_self_id, r_ttl_reload, r_any_robot, r_any_message;
    logic [2:0] r_control_loc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_id     <= '0;
            r_ttl_reload  <= 8'd8;
            r_any_robot   <= 8'hff;
            r_any_message <= 8'hff;
            r_control_loc <= 3'd7;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SELF_ID:     r_self_id     <= i_cfg_data;
                REG_TTL_RELOAD:  r_ttl_reload  <= i_cfg_data;
                REG_ANY_ROBOT:   r_any_robot   <= i_cfg_data;
                REG_ANY_MESSAGE: r_any_message <= i_cfg_data;
                REG_CONTROL_LOC: r_control_loc <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    t_state     r_state, n_state;
    t_in_item   r_item;
    logic [CW-1:0] r_cnt, n_cnt;      // read address issued
    logic       r_rvld;               // read data valid this cycle
    logic [AW-1:0] r_ridx;            // index of data in rd
    logic [AW-1:0] r_oldest, n_oldest;
    logic [7:0] r_oldest_ttl, n_oldest_ttl;
    logic       r_match, n_match;
    logic [AW-1:0] r_match_idx, n_match_idx;
    t_entry     r_match_e, n_match_e, r_oldest_e, n_oldest_e;
    logic       r_found, n_found, r_stop, n_stop;
    logic [7:0] r_best, n_best;
    t_entry     r_hit, n_hit;
    logic [7:0] r_obst, n_obst;
    logic       r_valid, n_valid;
    logic       r_is_store, n_is_store;
    logic       r_done, n_done;
    logic       r_init;               // clearing pass after reset
    t_out_item  r_res, n_res;

    logic       we;
    logic [AW-1:0] waddr, raddr;
    t_entry     wdata, rd;

    ttlnm_table_ram #(.ENTRIES(ENTRIES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rd)
    );

    // while idle, fetch the oldest entry so its un-aged count is at hand
    assign raddr = (r_state == ST_IDLE) ? r_oldest : r_cnt[AW-1:0];

    logic accept;
    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
            r_rvld  <= 1'b0;
            r_obst  <= '0;
            r_valid <= 1'b0;
            r_oldest <= '0;
            r_done  <= 1'b0;
            r_init  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rvld  <= (r_state == ST_SCAN) && (r_cnt < LAST);
            r_obst  <= n_obst;
            r_valid <= n_valid;
            r_oldest <= n_oldest;
            r_done  <= n_done;
            if (r_state == ST_CLEAR && r_cnt == LAST - CW'(1)) r_init <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_item <= i_item;
        r_ridx       <= r_cnt[AW-1:0];
        r_oldest_ttl <= n_oldest_ttl;
        r_match      <= n_match;
        r_match_idx  <= n_match_idx;
        r_match_e    <= n_match_e;
        r_oldest_e   <= n_oldest_e;
        r_found      <= n_found;
        r_stop       <= n_stop;
        r_best       <= n_best;
        r_hit        <= n_hit;
        r_is_store   <= n_is_store;
        r_res        <= n_res;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

    always_comb begin
        logic [7:0] ttl_dec;
        t_entry     e;
        n_state = r_state;
        n_cnt = r_cnt;
        n_obst = r_obst;
        n_valid = r_valid;
        n_oldest = r_oldest;
        n_oldest_ttl = r_oldest_ttl;
        n_match = r_match;
        n_match_idx = r_match_idx;
        n_match_e = r_match_e;
        n_oldest_e = r_oldest_e;
        n_found = r_found;
        n_stop = r_stop;
        n_best = r_best;
        n_hit = r_hit;
        n_is_store = r_is_store;
        n_done = 1'b0;
        n_res = r_res;
        we = 1'b0;
        waddr = r_ridx;
        wdata = rd;
        e = rd;
        ttl_dec = (rd.ttl != 8'd0) ? rd.ttl - 8'd1 : 8'd0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cnt = '0;
                    n_match = 1'b0;
                    n_found = 1'b0;
                    n_stop = 1'b0;
                    n_best = '0;
                    n_hit = '0;
                    n_is_store = 1'b0;
                    n_oldest_ttl = 8'd0;
                    n_state = ST_SCAN;
                    if (i_item.action == ACT_CLEAR) begin
                        n_state = ST_CLEAR;
                        n_valid = 1'b0;
                        n_obst = '0;
                        n_oldest = '0;
                    end else if (i_item.action == ACT_RECEIVE) begin
                        if (i_item.location >= r_control_loc) begin
                            n_valid = 1'b1;
                        end else if (i_item.sender_id == r_self_id) begin
                            n_obst = r_obst | (8'd1 << i_item.location);
                        end else begin
                            n_is_store = 1'b1;
                        end
                    end else if (i_item.action == ACT_QUERY) begin
                        n_obst = refresh_mask(r_obst);
                    end
                end
            end
            ST_SCAN: begin
                if (r_cnt < LAST) n_cnt = r_cnt + CW'(1);
                // first scan cycle: rd holds the oldest entry fetched while idle
                if (!r_rvld && r_cnt == '0 && r_is_store) n_oldest_ttl = rd.ttl;
                if (r_rvld) begin
                    if (r_is_store) begin
                        // age the entry and write it back
                        e.ttl = ttl_dec;
                        we = 1'b1;
                        wdata = e;
                        if (ttl_dec != 8'd0 && !r_match && rd.robot == r_item.sender_id
                            && rd.message == r_item.message_id) begin
                            n_match = 1'b1;
                            n_match_idx = r_ridx;
                            n_match_e = e;
                        end
                        // oldest count stays un-aged until the walk reaches it
                        if (r_ridx == r_oldest || ttl_dec < r_oldest_ttl) begin
                            n_oldest = r_ridx;
                            n_oldest_ttl = ttl_dec;
                            n_oldest_e = e;
                        end
                    end else if (r_item.action == ACT_QUERY && rd.ttl != 8'd0) begin
                        e.position = refresh_mask(rd.position);
                        we = 1'b1;
                        wdata = e;
                        if (!r_stop) begin
                            if (e.robot == r_item.query_robot
                                && e.message == r_item.query_message) begin
                                n_found = 1'b1; n_hit = e; n_stop = 1'b1;
                            end else if (r_item.query_robot == r_any_robot
                                && e.message == r_item.query_message) begin
                                if (r_best <= e.param) begin
                                    n_found = 1'b1; n_hit = e; n_best = e.param;
                                end
                            end else if (e.robot == r_item.query_robot
                                && r_item.query_message == r_any_message) begin
                                n_found = 1'b1; n_hit = e; n_stop = 1'b1;
                            end
                        end
                    end
                end
                if (!r_rvld && r_cnt == LAST) n_state = r_is_store ? ST_WRITE : ST_DONE;
            end
            ST_WRITE: begin
                e = r_match ? r_match_e : r_oldest_e;
                e.robot = r_item.sender_id;
                e.message = r_item.message_id;
                e.param = r_item.message_param;
                e.position = e.position | (8'd1 << r_item.location);
                e.ttl = r_ttl_reload;
                we = 1'b1;
                waddr = r_match ? r_match_idx : r_oldest;
                wdata = e;
                n_state = ST_DONE;
            end
            ST_CLEAR: begin
                e = '0;
                we = 1'b1;
                waddr = r_cnt[AW-1:0];
                wdata = e;
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == LAST - CW'(1)) begin
                    n_cnt = '0;
                    // the pass after reset answers nothing
                    n_state = r_init ? ST_IDLE : ST_DONE;
                end
            end
            ST_DONE: begin
                n_done = 1'b1;
                n_res.found = r_found;
                n_res.hit_robot = r_found ? r_hit.robot : 8'd0;
                n_res.hit_message = r_found ? r_hit.message : 8'd0;
                n_res.hit_param = r_found ? r_hit.param : 8'd0;
                n_res.hit_position = r_found ? r_hit.position : 8'd0;
                n_res.obstacle_mask = r_obst;
                n_res.info_valid = r_valid;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe lasted more than one cycle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while still busy");

endmodule
